// ===== hw/rtl/fjov_pkg.sv =====
// Package with phase codes, error codes and byte constants of the JSON object validator.
`default_nettype none
package fjov_pkg;
   typedef enum logic [10:0] {
      PH_OPEN    = 11'b00000000001,
      PH_MEMBER  = 11'b00000000010,
      PH_KEY     = 11'b00000000100,
      PH_KEY_END = 11'b00000001000,
      PH_VALUE   = 11'b00000010000,
      PH_STRING  = 11'b00000100000,
      PH_NUMBER  = 11'b00001000000,
      PH_AFTER   = 11'b00010000000,
      PH_CLOSED  = 11'b00100000000,
      PH_DONE    = 11'b01000000000,
      PH_STOP    = 11'b10000000000
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_SYNTAX   = 3'd1,
      ERR_PAIRS    = 3'd2,
      ERR_KEY_LONG = 3'd3,
      ERR_VAL_LONG = 3'd4,
      ERR_DUP      = 3'd5,
      ERR_TRAIL    = 3'd6
   } err_type;

   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW    = 8'h20;
   localparam logic [7:0] CH_HIGH   = 8'h7e;
   localparam logic [7:0] CH_NUL    = 8'h00;

   function automatic logic str_ok(input logic [7:0] b);
      return (b >= CH_LOW) && (b <= CH_HIGH) && (b != CH_QUOTE) && (b != CH_BSLASH);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/fjov_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module fjov_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/flat_json_object_validator_top.sv =====
// Top level of the strict flat JSON object validator.
//
// The validator takes one byte of a JSON object text per req_ transfer and, on the
// transfer marked by req_tlast, delivers one rsp_ transfer with the verdict, the first
// error code and the number of complete pairs. Keys are kept in a key memory of
// MAX_PAIR_COUNT*KEY_CAPACITY bytes and their lengths in a length memory. A key byte and
// a closing key quote also sweep every key already held in the object: the byte is
// compared against the same position of every earlier key (a closing quote against its
// length) through the single read port of the key memory (or the length memory), one key
// per SQ_SCAN read and SQ_CHECK compare; a new key meets at most MAX_PAIR_COUNT-1 stored
// keys. After the final byte the next transfer waits until the result has left the output
// register. No clearing pass is needed after reset: only keys written for the current text
// are ever read.
`default_nettype none
module flat_json_object_validator_top
   import fjov_pkg::*;
#(
   parameter int MAX_PAIR_COUNT = 20,
   parameter int KEY_CAPACITY   = 40,
   parameter int VALUE_CAPACITY = 192
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] text_byte
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [15:0]     rsp_tdata    // [0] object_valid, [3:1] error_kind,
                                        // [8:4] pairs_seen, rest zero
);
   localparam int PW  = $clog2(MAX_PAIR_COUNT + 1);
   localparam int PIW = (MAX_PAIR_COUNT > 1) ? $clog2(MAX_PAIR_COUNT) : 1;
   localparam int RW  = $clog2(((KEY_CAPACITY > VALUE_CAPACITY) ? KEY_CAPACITY
                                                                 : VALUE_CAPACITY) + 1);
   localparam int KD  = MAX_PAIR_COUNT * KEY_CAPACITY;
   localparam int KAW = $clog2(KD);
   localparam int LW  = $clog2(KEY_CAPACITY + 1);

   // Sequencer: take a byte, sweep the stored keys, finish.
   typedef enum logic [3:0] {
      SQ_IDLE  = 4'b0001,
      SQ_SCAN  = 4'b0010,
      SQ_CHECK = 4'b0100,
      SQ_FIN   = 4'b1000
   } seq_type;

   seq_type                 seq_ff, seq_in;
   phase_type               phase_ff, phase_in;
   err_type                 err_ff, err_in;
   logic [PW-1:0]           pairs_ff, pairs_in;
   logic [RW-1:0]           run_ff, run_in;
   logic [MAX_PAIR_COUNT-1:0] eq_ff, eq_in;
   logic                    ended_ff, ended_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    last_ff, last_in;
   logic                    close_ff, close_in;   // sweep compares lengths, not bytes
   logic [PIW-1:0]          idx_ff, idx_in;       // key currently compared
   logic [KAW-1:0]          base_ff, base_in;     // address of this key's first byte
   logic                    ovld_ff, ovld_in;
   logic [15:0]             odata_ff, odata_in;

   logic                    kw_en, lw_en;
   logic [KAW-1:0]          kw_addr, kr_addr;
   logic [7:0]              kr_data;
   logic [PIW-1:0]          lw_addr, lr_addr;
   logic [LW-1:0]           lr_data;

   fjov_ram #(.WIDTH(8), .DEPTH(KD)) u_key_ram (
      .clock(clock), .wr_en(kw_en), .wr_addr(kw_addr), .wr_data(byte_ff),
      .rd_addr(kr_addr), .rd_data(kr_data)
   );
   fjov_ram #(.WIDTH(LW), .DEPTH(MAX_PAIR_COUNT)) u_len_ram (
      .clock(clock), .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(run_ff[LW-1:0]),
      .rd_addr(lr_addr), .rd_data(lr_data)
   );

   logic accept;
   assign req_tready = (seq_ff == SQ_IDLE) && !ovld_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;

   // Sweep address: key idx_ff at position run_ff; the index that is read now is
   // compared in the following cycle.
   logic [KAW-1:0] scan_addr;
   assign scan_addr = base_ff + KAW'(run_ff);
   assign kr_addr   = scan_addr;
   assign lr_addr   = idx_ff;
   assign kw_addr   = KAW'(pairs_ff) * KAW'(KEY_CAPACITY) + KAW'(run_ff);
   assign lw_addr   = PIW'(pairs_ff);

   logic scan_needed;
   assign scan_needed = (pairs_ff != '0);

   // Next-state logic of the sequencer and the output register; one step of the byte parser runs in SQ_FIN.
   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      pairs_in = pairs_ff;
      run_in   = run_ff;
      eq_in    = eq_ff;
      ended_in = ended_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      close_in = close_ff;
      idx_in   = idx_ff;
      base_in  = base_ff;
      seq_in   = seq_ff;
      ovld_in  = ovld_ff;
      odata_in = odata_ff;
      kw_en    = 1'b0;
      lw_en    = 1'b0;

      if (ovld_ff && rsp_tready) begin
         ovld_in = 1'b0;
      end

      unique case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               byte_in  = req_tdata;
               last_in  = req_tlast;
               idx_in   = '0;
               base_in  = '0;
               close_in = (req_tdata == CH_QUOTE);
               if (ended_ff || err_ff != ERR_NONE) begin
                  seq_in = SQ_FIN;
               end else if (phase_ff == PH_KEY && scan_needed &&
                            (req_tdata == CH_QUOTE || (str_ok(req_tdata) &&
                             32'(run_ff) + 1 < KEY_CAPACITY))) begin
                  seq_in = SQ_SCAN;
               end else begin
                  seq_in = SQ_FIN;
               end
            end
         end
         SQ_SCAN: begin
            // Read of key idx_ff issued; compare next cycle.
            seq_in = SQ_CHECK;
         end
         SQ_CHECK: begin
            if (close_ff) begin
               if (LW'(run_ff) != lr_data) eq_in[idx_ff] = 1'b0;
            end else begin
               if (run_ff >= RW'(lr_data) || kr_data != byte_ff) eq_in[idx_ff] = 1'b0;
            end
            if (PW'(idx_ff) + 1'b1 >= pairs_ff) begin
               seq_in = SQ_FIN;
            end else begin
               idx_in  = idx_ff + 1'b1;
               base_in = base_ff + KAW'(KEY_CAPACITY);
               seq_in  = SQ_SCAN;
            end
         end
         SQ_FIN: begin
            if (!ended_ff && err_ff == ERR_NONE) begin
               unique case (phase_ff)
                  PH_OPEN: begin
                     if (byte_ff == CH_LBRACE) phase_in = PH_MEMBER;
                     else begin err_in = ERR_SYNTAX; phase_in = PH_STOP; end
                  end
                  PH_MEMBER: begin
                     if (byte_ff == CH_RBRACE) phase_in = PH_CLOSED;
                     else if (32'(pairs_ff) >= MAX_PAIR_COUNT) begin
                        err_in = ERR_PAIRS; phase_in = PH_STOP;
                     end else if (byte_ff == CH_QUOTE) begin
                        run_in = '0;
                        for (int i = 0; i < MAX_PAIR_COUNT; i++) begin
                           eq_in[i] = (i < 32'(pairs_ff));
                        end
                        phase_in = PH_KEY;
                     end else begin
                        err_in = ERR_SYNTAX; phase_in = PH_STOP;
                     end
                  end
                  PH_KEY: begin
                     if (byte_ff == CH_QUOTE) begin
                        lw_en    = 1'b1;
                        phase_in = PH_KEY_END;
                     end else if (!str_ok(byte_ff)) begin
                        err_in = ERR_SYNTAX; phase_in = PH_STOP;
                     end else if (32'(run_ff) + 1 >= KEY_CAPACITY) begin
                        err_in = ERR_KEY_LONG; phase_in = PH_STOP;
                     end else begin
                        kw_en  = 1'b1;
                        run_in = run_ff + 1'b1;
                     end
                  end
                  PH_KEY_END: begin
                     if (byte_ff != CH_COLON) begin
                        err_in = ERR_SYNTAX; phase_in = PH_STOP;
                     end else if (eq_ff != '0) begin
                        err_in = ERR_DUP; phase_in = PH_STOP;
                     end else phase_in = PH_VALUE;
                  end
                  PH_VALUE: begin
                     if (byte_ff == CH_QUOTE) begin
                        run_in = '0; phase_in = PH_STRING;
                     end else if (is_digit(byte_ff)) begin
                        run_in = RW'(1); phase_in = PH_NUMBER;
                     end else begin
                        err_in = ERR_SYNTAX; phase_in = PH_STOP;
                     end
                  end
                  PH_STRING: begin
                     if (byte_ff == CH_QUOTE) begin
                        pairs_in = pairs_ff + 1'b1; phase_in = PH_AFTER;
                     end else if (!str_ok(byte_ff)) begin
                        err_in = ERR_SYNTAX; phase_in = PH_STOP;
                     end else if (32'(run_ff) + 1 >= VALUE_CAPACITY) begin
                        err_in = ERR_VAL_LONG; phase_in = PH_STOP;
                     end else run_in = run_ff + 1'b1;
                  end
                  PH_NUMBER: begin
                     if (is_digit(byte_ff)) begin
                        if (32'(run_ff) + 1 >= VALUE_CAPACITY) begin
                           err_in = ERR_VAL_LONG; phase_in = PH_STOP;
                        end else run_in = run_ff + 1'b1;
                     end else begin
                        pairs_in = pairs_ff + 1'b1;
                        if (byte_ff == CH_COMMA) phase_in = PH_MEMBER;
                        else if (byte_ff == CH_RBRACE) phase_in = PH_CLOSED;
                        else begin err_in = ERR_SYNTAX; phase_in = PH_STOP; end
                     end
                  end
                  PH_AFTER: begin
                     if (byte_ff == CH_COMMA) phase_in = PH_MEMBER;
                     else if (byte_ff == CH_RBRACE) phase_in = PH_CLOSED;
                     else begin err_in = ERR_SYNTAX; phase_in = PH_STOP; end
                  end
                  PH_CLOSED: begin
                     if (byte_ff == CH_NUL) phase_in = PH_DONE;
                     else begin err_in = ERR_TRAIL; phase_in = PH_STOP; end
                  end
                  default: ;
               endcase
               if (byte_ff == CH_NUL) ended_in = 1'b1;
            end
            if (last_ff) begin
               // An early end is a zero byte: only the closed phase accepts it, and
               // a pair start with the store full reports the pair limit.
               if (!ended_in && err_in == ERR_NONE) begin
                  if (phase_in == PH_CLOSED) phase_in = PH_DONE;
                  else if (phase_in == PH_MEMBER &&
                           32'(pairs_in) >= MAX_PAIR_COUNT) begin
                     err_in = ERR_PAIRS;
                  end else if (phase_in == PH_KEY || phase_in == PH_STRING ||
                           phase_in == PH_OPEN || phase_in == PH_MEMBER ||
                           phase_in == PH_KEY_END || phase_in == PH_VALUE ||
                           phase_in == PH_AFTER) begin
                     err_in = ERR_SYNTAX;
                  end else if (phase_in == PH_NUMBER) begin
                     pairs_in = pairs_in + 1'b1;
                     err_in   = ERR_SYNTAX;
                  end
               end
               ovld_in  = 1'b1;
               odata_in = 16'({5'(pairs_in), err_in,
                               (err_in == ERR_NONE && phase_in == PH_DONE)});
               phase_in = PH_OPEN;
               pairs_in = '0;
               run_in   = '0;
               eq_in    = '0;
               err_in   = ERR_NONE;
               ended_in = 1'b0;
            end
            seq_in = SQ_IDLE;
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SQ_IDLE;
         phase_ff <= PH_OPEN;
         err_ff   <= ERR_NONE;
         pairs_ff <= '0;
         run_ff   <= '0;
         eq_ff    <= '0;
         ended_ff <= 1'b0;
         ovld_ff  <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
         pairs_ff <= pairs_in;
         run_ff   <= run_in;
         eq_ff    <= eq_in;
         ended_ff <= ended_in;
         ovld_ff  <= ovld_in;
      end
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      close_ff <= close_in;
      idx_ff   <= idx_in;
      base_ff  <= base_in;
      odata_ff <= odata_in;
   end

   // The pair count never exceeds its limit.
   a_pairs_limit: assert property (@(posedge clock) disable iff (reset)
      32'(pairs_ff) <= MAX_PAIR_COUNT)
      else $error("pair count above limit");
   // A key sweep only runs while a key is being parsed.
   a_scan_phase: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SQ_SCAN) |-> (phase_ff == PH_KEY))
      else $error("key sweep outside key phase");
   // A stalled result holds its data.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   // After a result is produced the parser is back at its start state.
   a_reset_after: assert property (@(posedge clock) disable iff (reset)
      $rose(ovld_ff) |-> (phase_ff == PH_OPEN && err_ff == ERR_NONE))
      else $error("parser not cleared after report");
endmodule
`default_nettype wire
